// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// File: rtl/rws_pkg.sv
// Package with constants, types and state codes of the roulette wheel selector.
`default_nettype none
package rws_pkg;
  localparam int unsigned PopSizeMax = 1024;
  localparam int unsigned IdxW = $clog2(PopSizeMax);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned FitW = 32;
  localparam int unsigned SumW = 42;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNotReady = 2'd1;
  localparam logic [1:0] StZeroFit = 2'd2;
  localparam logic [1:0] StSmallTot = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_BRD_LAST, S_BRD_F, S_DIV, S_ACC, S_FIN,
    S_TOT_RD, S_TOT, S_MOD, S_SRCH_RD, S_SRCH, S_OUT
  } state_e;

  typedef struct packed {
    logic store_fit;     // write fitness at count
    logic clear_pop;     // start a new population
    logic rd_fit_last;   // read last fitness
    logic cap_last;
    logic div_start;
    logic acc_write;     // accumulate and store prefix sum
    logic finish_build;
    logic rd_total;
    logic mod_start;
    logic srch_init;
    logic srch_step;
    logic out_draw;
    logic out_load;
    logic out_notready;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mod_done;
    logic build_last;    // build index at final entry
    logic srch_done;     // lo >= hi
    logic ready;
    logic err_nz;
    logic count_full;    // count reached the store size
  } sts_t;
endpackage
`default_nettype wire

// File: rtl/rws_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module rws_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write or registered read at one address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// File: rtl/rws_divider.sv
// Radix-2 restoring divider for quotient or remainder, one bit per cycle.
`default_nettype none
module rws_divider (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [rws_pkg::SumW-1:0]  dividend_i,
  input  wire logic [rws_pkg::SumW-1:0]  divisor_i,
  output logic                           done_o,
  output logic      [rws_pkg::SumW-1:0]  quot_o,
  output logic      [rws_pkg::SumW-1:0]  rem_o
);
  import rws_pkg::*;
  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0] quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [StepW-1:0] step_q, step_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [SumW:0] trial;

  assign trial = {rem_q, quot_q[SumW-1]} - {1'b0, dvs_q};

  // One shift-subtract step per cycle.
  always_comb begin
    quot_d = quot_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      step_d = StepW'(SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[SumW]) begin
        rem_d = {rem_q[SumW-2:0], quot_q[SumW-1]};
        quot_d = {quot_q[SumW-2:0], 1'b0};
      end else begin
        rem_d = trial[SumW-1:0];
        quot_d = {quot_q[SumW-2:0], 1'b1};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o = rem_q;
endmodule
`default_nettype wire

// File: rtl/rws_datapath.sv
// Datapath: fitness and prefix-sum memories, divider, search registers.
`default_nettype none
module rws_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rws_pkg::cmd_t              cmd_i,
  output rws_pkg::sts_t                   sts_o,
  input  wire logic [rws_pkg::FitW-1:0]   fitness_value_i,
  input  wire logic [rws_pkg::FitW-1:0]   random_value_i,
  output logic      [1:0]                 status_o,
  output logic      [9:0]                 selected_index_o,
  output logic                            wheel_ready_o
);
  import rws_pkg::*;

  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] bidx_q, lo_q, hi_q, mid;
  logic ready_q;
  logic [1:0] err_q, status_q;
  logic [9:0] sel_q;
  logic [FitW-1:0] last_q;
  logic [FitW-1:0] rnd_q;
  logic [SumW-1:0] acc_q, target_q;
  logic [CntW-1:0] cnt_new;

  // Fitness memory port.
  logic fit_we;
  logic [IdxW-1:0] fit_addr;
  logic [FitW-1:0] fit_rd;
  assign fit_we = cmd_i.store_fit;
  assign cnt_new = cmd_i.clear_pop ? '0 : count_q;
  always_comb begin
    fit_addr = bidx_q;
    if (cmd_i.store_fit) fit_addr = cnt_new[IdxW-1:0];
    else if (cmd_i.rd_fit_last) fit_addr = IdxW'(count_q - 1'b1);
  end
  rws_ram #(.Width(FitW), .Depth(PopSizeMax)) u_fit_ram (
    .clk_i, .we_i(fit_we), .addr_i(fit_addr), .wdata_i(fitness_value_i), .rdata_o(fit_rd)
  );

  // Divider shared by weight division and target modulo.
  logic [SumW-1:0] dvd, dvs, quot, rem;
  logic div_done;
  logic [SumW-1:0] sum_rd;
  assign dvd = cmd_i.mod_start ? SumW'(rnd_q) : SumW'(last_q);
  assign dvs = cmd_i.mod_start ? sum_rd - 1'b1 : SumW'(fit_rd);
  rws_divider u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start | cmd_i.mod_start),
    .dividend_i(dvd), .divisor_i(dvs), .done_o(div_done), .quot_o(quot), .rem_o(rem)
  );

  // Weight with zero-fitness check, then saturating accumulate.
  logic fzero_q;
  logic [SumW:0] acc_sum;
  logic [SumW-1:0] acc_new;
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) fzero_q <= (fit_rd == '0);
  end
  assign acc_sum = {1'b0, acc_q} + {1'b0, fzero_q ? {SumW{1'b0}} : quot};
  assign acc_new = (acc_sum > {1'b0, SumMax}) ? SumMax : acc_sum[SumW-1:0];

  // Prefix-sum memory port.
  logic [IdxW-1:0] sum_addr;
  always_comb begin
    sum_addr = mid;
    if (cmd_i.acc_write) sum_addr = bidx_q;
    else if (cmd_i.rd_total) sum_addr = IdxW'(count_q - 1'b1);
  end
  rws_ram #(.Width(SumW), .Depth(PopSizeMax)) u_sum_ram (
    .clk_i, .we_i(cmd_i.acc_write), .addr_i(sum_addr), .wdata_i(acc_new), .rdata_o(sum_rd)
  );

  assign mid = IdxW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

  // Control registers of the population.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ready_q <= 1'b0;
      err_q <= StOk;
    end else begin
      if (cmd_i.store_fit) begin
        count_q <= cnt_new + 1'b1;
        if (cmd_i.clear_pop) begin
          ready_q <= 1'b0;
          err_q <= StOk;
        end
      end
      if (cmd_i.acc_write && fzero_q) err_q <= StZeroFit;
      if (cmd_i.finish_build) begin
        ready_q <= 1'b1;
        if (err_q == StOk && acc_q < SumW'(2)) err_q <= StSmallTot;
      end
    end
  end

  // Build and search working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_last) begin
      last_q <= fit_rd;
      bidx_q <= '0;
      acc_q <= '0;
    end
    if (cmd_i.acc_write) begin
      acc_q <= acc_new;
      bidx_q <= bidx_q + 1'b1;
    end
    // The random word is held from the accepting edge of a draw.
    if (cmd_i.rd_total) rnd_q <= random_value_i;
    if (cmd_i.srch_init) begin
      target_q <= rem + 1'b1;
      lo_q <= '0;
      hi_q <= IdxW'(count_q - 1'b1);
    end
    if (cmd_i.srch_step) begin
      if (sum_rd >= target_q) hi_q <= mid;
      else lo_q <= mid + 1'b1;
    end
    if (cmd_i.out_draw) begin
      status_q <= err_q;
      sel_q <= (err_q == StOk) ? 10'(lo_q) : '0;
    end
    if (cmd_i.out_load) begin
      status_q <= err_q;
      sel_q <= '0;
    end
    if (cmd_i.out_notready) begin
      status_q <= StNotReady;
      sel_q <= '0;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.mod_done = div_done;
  assign sts_o.build_last = (CntW'(bidx_q) == count_q - 1'b1);
  assign sts_o.srch_done = (lo_q >= hi_q);
  assign sts_o.ready = ready_q;
  assign sts_o.err_nz = (err_q != StOk);
  assign sts_o.count_full = (count_q >= CntW'(PopSizeMax));

  assign status_o = status_q;
  assign selected_index_o = sel_q;
  assign wheel_ready_o = ready_q;
endmodule
`default_nettype wire

// File: rtl/rws_ctrl.sv
// Controller state machine of the roulette wheel selector.
`default_nettype none
module rws_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           op_i,
  input  wire logic           last_entry_i,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire rws_pkg::sts_t  sts_i,
  output rws_pkg::cmd_t       cmd_o
);
  import rws_pkg::*;
  state_e state_q, state_d;
  logic last_q;

  // State register and last-entry mark.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && in_valid) last_q <= last_entry_i;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!op_i) begin
            cmd_o.store_fit = 1'b1;
            cmd_o.clear_pop = sts_i.ready | sts_i.count_full;
            state_d = S_LOAD;
          end else if (!sts_i.ready) begin
            cmd_o.out_notready = 1'b1;
            state_d = S_OUT;
          end else if (sts_i.err_nz) begin
            cmd_o.out_draw = 1'b1;
            state_d = S_OUT;
          end else begin
            cmd_o.rd_total = 1'b1;
            state_d = S_TOT;
          end
        end
      end
      S_LOAD: begin
        if (last_q || sts_i.count_full) begin
          cmd_o.rd_fit_last = 1'b1;
          state_d = S_BRD_LAST;
        end else begin
          cmd_o.out_load = 1'b1;
          state_d = S_OUT;
        end
      end
      S_BRD_LAST: begin
        cmd_o.cap_last = 1'b1;
        state_d = S_BRD_F;
      end
      // The fitness at the build index is read in this cycle.
      S_BRD_F: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        if (sts_i.div_done) begin
          cmd_o.acc_write = 1'b1;
          state_d = sts_i.build_last ? S_FIN : S_BRD_F;
        end
      end
      S_FIN: begin
        cmd_o.finish_build = 1'b1;
        state_d = S_TOT_RD;
      end
      S_TOT_RD: begin
        cmd_o.out_load = 1'b1;
        state_d = S_OUT;
      end
      S_TOT: begin
        cmd_o.mod_start = 1'b1;
        state_d = S_MOD;
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          cmd_o.srch_init = 1'b1;
          state_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (sts_i.srch_done) begin
          cmd_o.out_draw = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd_o.srch_step = 1'b1;
        state_d = S_SRCH_RD;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/roulette_wheel_parent_selector.sv
// A load that is neither last nor fills the store only stores its fitness; any other load
// also builds the wheel, one division per entry. A draw runs a modulo on the divider and then
// a binary search of at most 10 steps; a draw answered with an error status skips both.
// The bit-serial divider is shared by the build and the draw, and each RAM has one port.
// One transaction is in work at a time; the next is taken the cycle after the result is taken.
// Reset clears the entry count, ready and error flags; memories are not cleared.
`default_nettype none
`include "assert_macros.svh"
module roulette_wheel_parent_selector (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      op_i,
  input  wire logic [rws_pkg::FitW-1:0]  fitness_value_i,
  input  wire logic                      last_entry_i,
  input  wire logic [rws_pkg::FitW-1:0]  random_value_i,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic      [1:0]                status_o,
  output logic      [9:0]                selected_index_o,
  output logic                           wheel_ready_o
);
  import rws_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic pick_nz;

  rws_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .op_i, .last_entry_i,
    .out_valid, .out_ready, .sts_i(sts), .cmd_o(cmd)
  );

  rws_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .fitness_value_i, .random_value_i,
    .status_o, .selected_index_o, .wheel_ready_o
  );

  // An ok result that names a nonzero index.
  assign pick_nz = out_valid && status_o == StOk && selected_index_o != 10'd0;

  // Checks on control behavior.
  `ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, out_valid, !in_ready)
  `ASSERT_IMPL(a_ok_ready, clk_i, rst_ni, pick_nz, wheel_ready_o)
  `ASSERT_NEXT(a_load_done, clk_i, rst_ni, cmd.finish_build, wheel_ready_o)
endmodule
`default_nettype wire
